// ----- rtl/core/fts_pkg.sv -----
`timescale 1ns / 1ps
// fts_pkg: widths, reset values, shared types and the slice arithmetic of the
// frame time slew corrector. No dependencies.
package fts_pkg;

  // Field and datapath widths
  localparam int unsigned DUR_W   = 20;  // update duration, us
  localparam int unsigned SHIFT_W = 16;  // signed frame index shift
  localparam int unsigned CORR_W  = 36;  // signed correction
  localparam int unsigned MAG_W   = 35;  // |correction|
  localparam int unsigned SLICE_W = 23;  // signed slice
  localparam int unsigned SMAG_W  = 22;  // |slice|, bounded by 3 * duration
  localparam int unsigned FLOOR_W = 15;  // duration / 50
  localparam int unsigned CAPN_W  = 20;  // 3 * duration / 4
  localparam int unsigned DIV_W   = 25;  // |c| range that needs an exact /6
  localparam int unsigned QUO_W   = 23;  // width of (2^DIV_W - 1) / 6

  // Request kinds
  localparam logic MODE_SHIFT = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Reset configuration
  localparam int unsigned DUR_RESET_VAL = 16667;
  localparam logic [DUR_W-1:0]   DUR_RESET   = DUR_W'(DUR_RESET_VAL);
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(DUR_RESET_VAL / 50);
  localparam logic [SMAG_W-1:0]  CAPP_RESET  = SMAG_W'(3 * DUR_RESET_VAL);
  localparam logic [CAPN_W-1:0]  CAPN_RESET  = CAPN_W'((3 * DUR_RESET_VAL) / 4);

  // Reciprocal constants: x/6 for x < 2^25, and y/25 for y < 2^19
  localparam int unsigned R6_W       = 26;
  localparam int unsigned RECIP6_SH  = 28;
  localparam logic [R6_W-1:0] RECIP6 = 26'd44739243;   // ceil(2^28 / 6)
  localparam int unsigned P6_W       = DIV_W + R6_W;
  localparam int unsigned R25_W      = 20;
  localparam int unsigned RECIP25_SH = 24;
  localparam logic [R25_W-1:0] RECIP25 = 20'd671089;   // ceil(2^24 / 25)
  localparam int unsigned P50_W      = DUR_W - 1 + R25_W;

  typedef struct packed {
    logic [DUR_W-1:0]   dur;
    logic [FLOOR_W-1:0] floor_us;  // minimum slice
    logic [SMAG_W-1:0]  cap_pos;   // slice cap for a positive correction
    logic [CAPN_W-1:0]  cap_neg;   // slice cap for a negative correction
  } cfg_t;

  typedef struct packed {
    logic                     mode;
    logic                     neg;   // proposal sign
    logic [MAG_W-1:0]         mag;   // |shift| * duration
    logic signed [CORR_W-1:0] val;   // shift * duration
  } prop_t;

  // floor(x / 50) = floor(floor(x / 2) / 25)
  function automatic logic [FLOOR_W-1:0] div50(input logic [DUR_W-1:0] x);
    logic [P50_W-1:0] prod;
    prod = {{(P50_W-DUR_W+1){1'b0}}, x[DUR_W-1:1]} * {{(P50_W-R25_W){1'b0}}, RECIP25};
    return prod[RECIP25_SH +: FLOOR_W];
  endfunction

  function automatic logic [QUO_W-1:0] div6(input logic [DIV_W-1:0] x);
    logic [P6_W-1:0] prod;
    prod = {{(P6_W-DIV_W){1'b0}}, x} * {{(P6_W-R6_W){1'b0}}, RECIP6};
    return prod[RECIP6_SH +: QUO_W];
  endfunction

  // Magnitude of the slice that one tick removes from a correction.
  // Above 2^25 the quotient |c|/6 is beyond any cap, so only the cap matters.
  function automatic logic [SMAG_W-1:0] slice_mag(input logic [MAG_W-1:0] mag,
                                                  input logic             neg,
                                                  input cfg_t             cfg);
    logic [SMAG_W-1:0] cap;
    logic [QUO_W-1:0]  quo;
    logic [QUO_W-1:0]  frac;
    logic [SMAG_W-1:0] res;
    cap  = neg ? {{(SMAG_W-CAPN_W){1'b0}}, cfg.cap_neg} : cfg.cap_pos;
    quo  = div6(mag[DIV_W-1:0]);
    frac = (quo < {{(QUO_W-FLOOR_W){1'b0}}, cfg.floor_us}) ?
           {{(QUO_W-FLOOR_W){1'b0}}, cfg.floor_us} : quo;
    if (mag < {{(MAG_W-FLOOR_W){1'b0}}, cfg.floor_us}) begin
      res = mag[SMAG_W-1:0];
    end else if (mag[MAG_W-1:DIV_W] != '0) begin
      res = cap;
    end else if (frac < {{(QUO_W-SMAG_W){1'b0}}, cap}) begin
      res = frac[SMAG_W-1:0];
    end else begin
      res = cap;
    end
    return res;
  endfunction

  function automatic logic signed [SLICE_W-1:0] to_slice(input logic [SMAG_W-1:0] sm,
                                                         input logic              neg);
    logic signed [SLICE_W-1:0] v;
    v = $signed({{(SLICE_W-SMAG_W){1'b0}}, sm});
    return neg ? -v : v;
  endfunction

endpackage

// ----- rtl/core/fts_req_if.sv -----
`timescale 1ns / 1ps
// fts_req_if: request channel of the slew corrector (valid/ready + payload).
// Depends on fts_pkg.
interface fts_req_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [fts_pkg::SHIFT_W-1:0]  index_shift;

  modport source (output valid, output mode, output index_shift, input ready);
  modport sink   (input valid, input mode, input index_shift, output ready);
endinterface

// ----- rtl/core/fts_rsp_if.sv -----
`timescale 1ns / 1ps
// fts_rsp_if: result channel of the slew corrector (valid/ready + payload).
// Depends on fts_pkg.
interface fts_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [fts_pkg::CORR_W-1:0]   correction_left;
  logic signed [fts_pkg::SLICE_W-1:0]  frame_correction;

  modport source (output valid, output correction_left, output frame_correction,
                  input ready);
  modport sink   (input valid, input correction_left, input frame_correction,
                  output ready);
endinterface

// ----- rtl/core/fts_cfg.sv -----
`timescale 1ns / 1ps
// fts_cfg: update duration register plus the derived floor and cap values.
// Depends on fts_pkg.
module fts_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fts_pkg::DUR_W-1:0]  cfg_wdata_i,
  output fts_pkg::cfg_t              cfg_o
);

  fts_pkg::cfg_t                 cfg_q, cfg_d;
  logic [fts_pkg::SMAG_W-1:0]    cap3;

  // 3 * duration = d + 2d
  assign cap3 = {2'b00, cfg_wdata_i} + {1'b0, cfg_wdata_i, 1'b0};

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      cfg_d.dur      = cfg_wdata_i;
      cfg_d.floor_us = fts_pkg::div50(cfg_wdata_i);
      cfg_d.cap_pos  = cap3;
      cfg_d.cap_neg  = cap3[fts_pkg::SMAG_W-1:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dur:      fts_pkg::DUR_RESET,
                 floor_us: fts_pkg::FLOOR_RESET,
                 cap_pos:  fts_pkg::CAPP_RESET,
                 cap_neg:  fts_pkg::CAPN_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/fts_prop.sv -----
`timescale 1ns / 1ps
// fts_prop: request register and the shift * duration proposal stage.
// Depends on fts_pkg and fts_req_if.
module fts_prop (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fts_pkg::cfg_t  cfg_i,
  fts_req_if.sink        req_i,
  output logic           prop_valid_o,
  input  logic           prop_ready_i,
  output fts_pkg::prop_t prop_o
);

  logic                                a_valid_q;
  logic                                a_mode_q;
  logic signed [fts_pkg::SHIFT_W-1:0]  a_shift_q;
  logic                                b_valid_q;
  fts_pkg::prop_t                      b_q, b_d;
  logic [fts_pkg::SHIFT_W-1:0]         shift_abs;
  logic                                b_free;
  logic                                a_adv;

  assign b_free      = !b_valid_q || prop_ready_i;
  assign a_adv       = a_valid_q && b_free;
  assign req_i.ready = !a_valid_q || b_free;

  always_comb begin
    // -(-32768) keeps the pattern 0x8000, which is 32768 unsigned
    shift_abs = a_shift_q[fts_pkg::SHIFT_W-1] ? $unsigned(-a_shift_q) : $unsigned(a_shift_q);
    b_d.mode  = a_mode_q;
    b_d.neg   = a_shift_q[fts_pkg::SHIFT_W-1];
    b_d.mag   = {{(fts_pkg::MAG_W-fts_pkg::SHIFT_W){1'b0}}, shift_abs} *
                {{(fts_pkg::MAG_W-fts_pkg::DUR_W){1'b0}}, cfg_i.dur};
    b_d.val   = $signed({{(fts_pkg::CORR_W-fts_pkg::SHIFT_W){a_shift_q[fts_pkg::SHIFT_W-1]}},
                         a_shift_q}) *
                $signed({{(fts_pkg::CORR_W-fts_pkg::DUR_W){1'b0}}, cfg_i.dur});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        a_valid_q <= req_i.valid;
      end
      if (b_free) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      a_mode_q  <= req_i.mode;
      a_shift_q <= req_i.index_shift;
    end
    if (a_adv) begin
      b_q <= b_d;
    end
  end

  assign prop_valid_o = b_valid_q;
  assign prop_o       = b_q;

  // signed proposal and its sign/magnitude form must agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && (b_q.mode == fts_pkg::MODE_SHIFT) |->
      b_q.val == (b_q.neg ? -$signed({1'b0, b_q.mag}) : $signed({1'b0, b_q.mag})))
    else $error("fts_prop: proposal value and magnitude disagree");

  // a request held in the input register is never dropped while blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !b_free |=> a_valid_q && $stable(a_mode_q) && $stable(a_shift_q))
    else $error("fts_prop: blocked request lost");

endmodule

// ----- rtl/core/fts_core.sv -----
`timescale 1ns / 1ps
// fts_core: correction state, shift/tick update, slice and result register.
// Depends on fts_pkg and fts_rsp_if.
module fts_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fts_pkg::cfg_t  cfg_i,
  input  logic           prop_valid_i,
  output logic           prop_ready_o,
  input  fts_pkg::prop_t prop_i,
  fts_rsp_if.source      rsp_o
);

  logic signed [fts_pkg::CORR_W-1:0]  corr_q, corr_d;
  logic [fts_pkg::MAG_W-1:0]          mag_q, mag_d;
  logic                               neg_q, neg_d;
  logic                               rsp_valid_q;
  logic signed [fts_pkg::CORR_W-1:0]  left_q;
  logic signed [fts_pkg::SLICE_W-1:0] slice_q, slice_d;
  logic [fts_pkg::SMAG_W-1:0]         sm_state, sm_prop, sm_out;
  logic signed [fts_pkg::CORR_W-1:0]  sm_state_ext;
  logic                               sl_neg, replace, corr_pos, prop_pos, step;

  assign prop_ready_o = !rsp_valid_q || rsp_o.ready;
  assign step         = prop_valid_i && prop_ready_o;

  always_comb begin
    sm_state     = fts_pkg::slice_mag(mag_q, neg_q, cfg_i);
    sm_prop      = fts_pkg::slice_mag(prop_i.mag, prop_i.neg, cfg_i);
    sm_state_ext = $signed({{(fts_pkg::CORR_W-fts_pkg::SMAG_W){1'b0}}, sm_state});
    corr_pos     = !neg_q && (mag_q != '0);
    prop_pos     = !prop_i.neg && (prop_i.mag != '0);
    // a zero store, a sign change or a smaller proposal takes over
    replace      = (mag_q == '0) || (corr_pos != prop_pos) || (prop_i.mag < mag_q);

    mag_d  = mag_q;
    neg_d  = neg_q;
    corr_d = corr_q;
    sm_out = sm_state;
    sl_neg = neg_q;
    if (prop_i.mode == fts_pkg::MODE_TICK) begin
      // slice has the sign of the correction and never exceeds it
      mag_d  = mag_q - {{(fts_pkg::MAG_W-fts_pkg::SMAG_W){1'b0}}, sm_state};
      corr_d = neg_q ? corr_q + sm_state_ext : corr_q - sm_state_ext;
    end else if (replace) begin
      mag_d  = prop_i.mag;
      neg_d  = prop_i.neg;
      corr_d = prop_i.val;
      sm_out = sm_prop;
      sl_neg = prop_i.neg;
    end
    slice_d = fts_pkg::to_slice(sm_out, sl_neg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q      <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (step) begin
        corr_q <= corr_d;
        mag_q  <= mag_d;
        neg_q  <= neg_d;
      end
      if (prop_ready_o) begin
        rsp_valid_q <= prop_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      left_q  <= corr_d;
      slice_q <= slice_d;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.correction_left  = left_q;
  assign rsp_o.frame_correction = slice_q;

  // signed copy and sign/magnitude copy of the state track each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    corr_q == (neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q})))
    else $error("fts_core: correction copies diverged");

  // a tick only ever shrinks the correction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (prop_i.mode == fts_pkg::MODE_TICK) |=> mag_q <= $past(mag_q))
    else $error("fts_core: tick grew the correction");

  // state moves only when a request reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> $stable(corr_q) && $stable(mag_q))
    else $error("fts_core: state changed while result stalled");

endmodule

// ----- rtl/core/frame_time_slew_corrector.sv -----
`timescale 1ns / 1ps
// frame_time_slew_corrector: top level, joins config, proposal stage and core.
// Depends on fts_pkg, fts_req_if, fts_rsp_if, fts_cfg, fts_prop, fts_core.
//
// Keeps a signed correction (us) still to be applied. A shift request
// (mode 0) proposes index_shift * update_duration_us and takes over the
// stored value when that is zero, of the other sign, or smaller in magnitude;
// the result shows the new value and the slice the next tick would remove.
// A tick request (mode 1) removes one slice: the whole remainder below
// duration/50, else max(|c|/6, duration/50) capped at 3*duration (positive)
// or 3*duration/4 (negative), all divisions truncating. One result per
// request, in order. Throughput is one request per clock while the result
// is taken. The request register loads when a request is accepted, then
// the proposal multiplier stage and the result register follow. The rate
// is set by the state loop, which computes the slice from the stored
// correction (a /6 by reciprocal multiply on the low 25 bits) and
// subtracts it combinationally, ahead of the state registers.
// A full result register does not block intake: the two earlier stages keep
// accepting until they are full. update_duration_us resets to 16667 and is
// written with cfg_we_i; write it only while no request is in flight. The
// floor and caps are derived from it at write time.
module frame_time_slew_corrector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fts_pkg::DUR_W-1:0]  cfg_wdata_i,
  fts_req_if.sink                    req_i,
  fts_rsp_if.source                  rsp_o
);

  fts_pkg::cfg_t  cfg;
  fts_pkg::prop_t prop;
  logic           prop_valid;
  logic           prop_ready;

  fts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fts_prop u_prop (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .req_i        (req_i),
    .prop_valid_o (prop_valid),
    .prop_ready_i (prop_ready),
    .prop_o       (prop)
  );

  fts_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .prop_valid_i (prop_valid),
    .prop_ready_o (prop_ready),
    .prop_i       (prop),
    .rsp_o        (rsp_o)
  );

endmodule
